FILE: sv/fexp_pkg.sv
// shared types, constants and single-precision arithmetic functions for the exp unit
`timescale 1ns / 1ps

package fexp_pkg;

    typedef logic [31:0] t_f32;

    // configuration register indexes
    localparam logic [1:0] CFG_UPPER    = 2'd0;
    localparam logic [1:0] CFG_LOWER    = 2'd1;
    localparam logic [1:0] CFG_OVERFLOW = 2'd2;

    // configuration reset values
    localparam t_f32 RST_UPPER    = 32'h42B1_7218;
    localparam t_f32 RST_LOWER    = 32'hC2CE_8ED0;
    localparam t_f32 RST_OVERFLOW = 32'h7F7F_FFFF;

    // float constants as bit patterns
    localparam t_f32 K_LOG2E = 32'h3FB8_AA3B;
    localparam t_f32 K_HALF  = 32'h3F00_0000;
    localparam t_f32 K_C1    = 32'h3F31_8000;
    localparam t_f32 K_C2    = 32'hB95E_8083;
    localparam t_f32 K_P0    = 32'h3950_6967;
    localparam t_f32 K_P1    = 32'h3AB7_43CE;
    localparam t_f32 K_P2    = 32'h3C08_8908;
    localparam t_f32 K_P3    = 32'h3D2A_A9C1;
    localparam t_f32 K_P4    = 32'h3E2A_AAAA;
    localparam t_f32 K_P5    = 32'h3F00_0000;
    localparam t_f32 K_ONE   = 32'h3F80_0000;
    localparam t_f32 QNAN    = 32'h7FC0_0000;
    localparam t_f32 NEG_ONE = 32'hBF80_0000;

    localparam logic signed [11:0] EXP_MAX  = 12'sd255;
    localparam logic signed [9:0]  N_CLAMP  = 10'sd400;

    // pipeline word carried from stage to stage
    typedef struct packed {
        logic valid;
        logic byp;
        t_f32 byp_val;
        t_f32 x;
        t_f32 z;
        t_f32 t;
        t_f32 p;
        t_f32 zz;
    } t_stage;

    typedef enum logic [1:0] {OPK_MUL, OPK_ADD, OPK_FLOOR} t_op_kind;
    typedef enum logic [2:0] {SRC_X, SRC_Z, SRC_T, SRC_P, SRC_ZZ, SRC_K} t_src;
    typedef enum logic [2:0] {DST_X, DST_Z, DST_T, DST_P, DST_ZZ} t_dst;

    typedef struct packed {
        t_op_kind kind;
        t_src     src_a;
        t_src     src_b;
        logic     neg_b;
        t_f32     kval;
        t_dst     dst;
    } t_op;

    localparam int NUM_OPS = 21;

    // one float operation per arithmetic pipeline stage, in evaluation order
    localparam t_op OP_TABLE [NUM_OPS] = '{
        '{OPK_MUL,   SRC_K, SRC_X,  1'b0, K_LOG2E, DST_T},
        '{OPK_ADD,   SRC_T, SRC_K,  1'b0, K_HALF,  DST_T},
        '{OPK_FLOOR, SRC_T, SRC_K,  1'b0, K_HALF,  DST_Z},
        '{OPK_MUL,   SRC_Z, SRC_K,  1'b0, K_C1,    DST_T},
        '{OPK_ADD,   SRC_X, SRC_T,  1'b1, K_C1,    DST_X},
        '{OPK_MUL,   SRC_Z, SRC_K,  1'b0, K_C2,    DST_T},
        '{OPK_ADD,   SRC_X, SRC_T,  1'b1, K_C2,    DST_X},
        '{OPK_MUL,   SRC_X, SRC_X,  1'b0, K_ONE,   DST_ZZ},
        '{OPK_MUL,   SRC_K, SRC_X,  1'b0, K_P0,    DST_P},
        '{OPK_ADD,   SRC_P, SRC_K,  1'b0, K_P1,    DST_P},
        '{OPK_MUL,   SRC_P, SRC_X,  1'b0, K_ONE,   DST_P},
        '{OPK_ADD,   SRC_P, SRC_K,  1'b0, K_P2,    DST_P},
        '{OPK_MUL,   SRC_P, SRC_X,  1'b0, K_ONE,   DST_P},
        '{OPK_ADD,   SRC_P, SRC_K,  1'b0, K_P3,    DST_P},
        '{OPK_MUL,   SRC_P, SRC_X,  1'b0, K_ONE,   DST_P},
        '{OPK_ADD,   SRC_P, SRC_K,  1'b0, K_P4,    DST_P},
        '{OPK_MUL,   SRC_P, SRC_X,  1'b0, K_ONE,   DST_P},
        '{OPK_ADD,   SRC_P, SRC_K,  1'b0, K_P5,    DST_P},
        '{OPK_MUL,   SRC_P, SRC_ZZ, 1'b0, K_ONE,   DST_P},
        '{OPK_ADD,   SRC_P, SRC_X,  1'b0, K_ONE,   DST_P},
        '{OPK_ADD,   SRC_P, SRC_K,  1'b0, K_ONE,   DST_P}
    };

    // leading zero counts
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic logic is_nan(input t_f32 a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    // round to nearest even and pack; m has leading one at bit 26, sticky at bit 0
    function automatic t_f32 round_pack(input logic s, input logic signed [11:0] e,
                                        input logic [26:0] m);
        logic [26:0] ms;
        logic [11:0] sh;
        logic [7:0]  ef;
        logic        st;
        logic        up;
        logic [30:0] body;
        if (e >= EXP_MAX) return {s, 8'hFF, 23'd0};
        if (e <= 12'sd0) begin
            sh = 12'(12'sd1 - e);
            if (sh > 12'd27) begin
                ms = {26'd0, |m};
            end else begin
                st = |(m & ((27'd1 << sh) - 27'd1));
                ms = (m >> sh) | {26'd0, st};
            end
            ef = 8'd0;
        end else begin
            ms = m;
            ef = e[7:0];
        end
        up   = ms[2] && (ms[1] || ms[0] || ms[3]);
        body = {ef, ms[25:3]} + 31'(up);
        return {s, body};
    endfunction

    // single-precision multiply
    function automatic t_f32 fmul(input t_f32 a, input t_f32 b);
        logic                s;
        logic                inf_a, inf_b, zero_a, zero_b;
        logic [23:0]         ma, mb;
        logic signed [11:0]  ea, eb, e;
        logic [47:0]         prod, pn;
        logic [5:0]          lz;
        s      = a[31] ^ b[31];
        inf_a  = (a[30:0] == 31'h7F80_0000);
        inf_b  = (b[30:0] == 31'h7F80_0000);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (inf_a || inf_b) begin
            if (zero_a || zero_b) return QNAN;
            return {s, 8'hFF, 23'd0};
        end
        if (zero_a || zero_b) return {s, 31'd0};
        ma   = {a[30:23] != 8'd0, a[22:0]};
        mb   = {b[30:23] != 8'd0, b[22:0]};
        ea   = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
        eb   = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
        prod = 48'(ma) * 48'(mb);
        lz   = lzc48(prod);
        pn   = prod << lz;
        e    = ea + eb - 12'sd126 - $signed({6'd0, lz});
        return round_pack(s, e, {pn[47:22], |pn[21:0]});
    endfunction

    // single-precision add
    function automatic t_f32 fadd(input t_f32 a, input t_f32 b);
        logic               inf_a, inf_b, zero_a, zero_b, swap;
        t_f32               big, sml;
        logic [7:0]         eb8, es8, d;
        logic [26:0]        mbig, msml, shd, m;
        logic               st;
        logic [27:0]        acc;
        logic [4:0]         lz;
        logic signed [11:0] e;
        inf_a  = (a[30:0] == 31'h7F80_0000);
        inf_b  = (b[30:0] == 31'h7F80_0000);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (inf_a && inf_b && (a[31] != b[31])) return QNAN;
        if (inf_a) return a;
        if (inf_b) return b;
        if (zero_a && zero_b) return {a[31] & b[31], 31'd0};
        swap = (a[30:0] < b[30:0]);
        big  = swap ? b : a;
        sml  = swap ? a : b;
        eb8  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es8  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = eb8 - es8;
        mbig = {big[30:23] != 8'd0, big[22:0], 3'b000};
        msml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        if (d >= 8'd27) begin
            shd = {26'd0, |msml};
        end else begin
            st  = |(msml & ((27'd1 << d) - 27'd1));
            shd = (msml >> d) | {26'd0, st};
        end
        if (big[31] == sml[31]) acc = {1'b0, mbig} + {1'b0, shd};
        else                    acc = {1'b0, mbig} - {1'b0, shd};
        if (acc == 28'd0) return 32'd0;
        if (acc[27]) begin
            m = {acc[27:2], |acc[1:0]};
            e = $signed({4'd0, eb8}) + 12'sd1;
        end else begin
            lz = lzc27(acc[26:0]);
            m  = acc[26:0] << lz;
            e  = $signed({4'd0, eb8}) - $signed({7'd0, lz});
        end
        return round_pack(big[31], e, m);
    endfunction

    // floor of a float, large or non-finite values pass through
    function automatic t_f32 ffloor(input t_f32 t);
        logic [7:0]  e;
        logic [23:0] mant, ip, nrm;
        logic [4:0]  sh, lz;
        logic        fnz;
        e = t[30:23];
        if (e >= 8'd150) return t;
        if (e < 8'd127) begin
            if (t[31] && (t[30:0] != 31'd0)) return NEG_ONE;
            return 32'd0;
        end
        mant = {1'b1, t[22:0]};
        sh   = 5'(8'd150 - e);
        ip   = mant >> sh;
        fnz  = |(mant & ((24'd1 << sh) - 24'd1));
        if (t[31] && fnz) ip = ip + 24'd1;
        lz   = lzc24(ip);
        nrm  = ip << lz;
        return {t[31], 8'(8'd150 - {3'd0, lz}), nrm[22:0]};
    endfunction

    // integral float to scale exponent, clamped
    function automatic logic signed [9:0] z_to_n(input t_f32 z);
        logic [7:0] e;
        logic [9:0] mag;
        logic [23:0] sm;
        e = z[30:23];
        if (is_nan(z)) return 10'sd0;
        if (e < 8'd127) return 10'sd0;
        if (e >= 8'd136) return z[31] ? -N_CLAMP : N_CLAMP;
        sm  = {1'b1, z[22:0]} >> (8'd150 - e);
        mag = sm[9:0];
        if (mag > 10'd400) mag = 10'd400;
        return z[31] ? -$signed(mag) : $signed(mag);
    endfunction

    // scale by a power of two with gradual underflow
    function automatic t_f32 fscale(input t_f32 b, input logic signed [9:0] n);
        logic               s;
        logic signed [11:0] e;
        logic [23:0]        m, q, r, half;
        logic [4:0]         lz;
        logic [11:0]        sh;
        s = b[31];
        if (b[30:23] == 8'hFF) return b;
        if (b[30:23] == 8'd0) begin
            if (b[22:0] == 23'd0) return b;
            m  = {1'b0, b[22:0]};
            lz = lzc24(m);
            m  = m << lz;
            e  = 12'sd1 - $signed({7'd0, lz});
        end else begin
            m = {1'b1, b[22:0]};
            e = $signed({4'd0, b[30:23]});
        end
        e = e + 12'(n);
        if (e >= EXP_MAX) return {s, 8'hFF, 23'd0};
        if (e >= 12'sd1) return {s, e[7:0], m[22:0]};
        sh = 12'(12'sd1 - e);
        if (sh > 12'd24) return {s, 31'd0};
        q    = m >> sh;
        r    = m & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 12'd1);
        if ((r > half) || ((r == half) && q[0])) q = q + 24'd1;
        return {s, 31'(q)};
    endfunction

    // ordered greater-than, false on any NaN
    function automatic logic fgt(input t_f32 a, input t_f32 b);
        t_f32 ka, kb;
        if (is_nan(a) || is_nan(b)) return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        return ka > kb;
    endfunction

    // operand fetch from the pipeline word
    function automatic t_f32 sel_src(input t_stage st, input t_src s, input t_f32 k);
        t_f32 v;
        unique case (s)
            SRC_X:   v = st.x;
            SRC_Z:   v = st.z;
            SRC_T:   v = st.t;
            SRC_P:   v = st.p;
            SRC_ZZ:  v = st.zz;
            SRC_K:   v = k;
            default: v = k;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/fexp_stage.sv
// one pipeline stage performing a single float operation on the pipeline word
`timescale 1ns / 1ps

module fexp_stage import fexp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_op    i_op,
    input  t_stage i_st,
    output t_stage o_st
);

    t_stage r_st;
    t_stage n_st;
    t_f32   w_a;
    t_f32   w_b;
    t_f32   w_res;

    // operand fetch
    always_comb begin
        w_a = sel_src(i_st, i_op.src_a, i_op.kval);
        w_b = sel_src(i_st, i_op.src_b, i_op.kval) ^ {i_op.neg_b, 31'd0};
    end

    // the operation itself
    always_comb begin
        unique case (i_op.kind)
            OPK_MUL:   w_res = fmul(w_a, w_b);
            OPK_ADD:   w_res = fadd(w_a, w_b);
            OPK_FLOOR: w_res = ffloor(w_a);
            default:   w_res = w_a;
        endcase
    end

    // write back to the destination field
    always_comb begin
        n_st = i_st;
        unique case (i_op.dst)
            DST_X:   n_st.x  = w_res;
            DST_Z:   n_st.z  = w_res;
            DST_T:   n_st.t  = w_res;
            DST_P:   n_st.p  = w_res;
            DST_ZZ:  n_st.zz = w_res;
            default: n_st.t  = w_res;
        endcase
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

FILE: sv/fexp_scale.sv
// final stage: power-of-two scaling, special results and output register
`timescale 1ns / 1ps

module fexp_scale import fexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_stage      i_st,
    output logic        o_valid,
    output logic [31:0] o_result_bits
);

    logic  r_valid;
    t_f32  r_result;
    t_f32  n_result;

    // pick bypass value, internal nan or scaled polynomial
    always_comb begin
        if (i_st.byp) begin
            n_result = i_st.byp_val;
        end else if (is_nan(i_st.p)) begin
            n_result = QNAN;
        end else begin
            n_result = fscale(i_st.p, z_to_n(i_st.z));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= i_st.valid;
            r_result <= n_result;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_bits = r_result;

endmodule

FILE: sv/float_exp_unit_core.sv
// top level of the single-precision exponential pipeline
// 23 register stages: the input register, 21 arithmetic stages and the scaling output register
// throughput: one item per cycle unless stalled; each arithmetic stage holds one float multiply, add or floor
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset: synchronous active-low, clears all valid bits and restores the limit registers
`timescale 1ns / 1ps

module float_exp_unit_core import fexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_arg_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_bits,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_f32   r_upper;
    t_f32   r_lower;
    t_f32   r_overflow;
    t_stage r_s0;
    t_stage n_s0;
    t_stage w_st [NUM_OPS+1];
    logic   w_en;

    // pipeline advances unless the held result is stalled
    assign o_stall = o_valid && i_stall;
    assign w_en    = !o_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper    <= RST_UPPER;
            r_lower    <= RST_LOWER;
            r_overflow <= RST_OVERFLOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UPPER:    r_upper    <= i_cfg_data;
                CFG_LOWER:    r_lower    <= i_cfg_data;
                CFG_OVERFLOW: r_overflow <= i_cfg_data;
                default:      r_upper    <= r_upper;
            endcase
        end
    end

    // argument classification against nan and the limits
    always_comb begin
        n_s0         = '0;
        n_s0.valid   = i_valid;
        n_s0.x       = i_arg_bits;
        n_s0.byp     = 1'b1;
        n_s0.byp_val = 32'd0;
        if (is_nan(i_arg_bits)) begin
            n_s0.byp_val = i_arg_bits | 32'h0040_0000;
        end else if (fgt(i_arg_bits, r_upper)) begin
            n_s0.byp_val = r_overflow;
        end else if (fgt(r_lower, i_arg_bits)) begin
            n_s0.byp_val = 32'd0;
        end else begin
            n_s0.byp = 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_en) begin
            r_s0 <= n_s0;
        end
    end

    assign w_st[0] = r_s0;

    // chain of arithmetic stages
    for (genvar k = 0; k < NUM_OPS; k++) begin : g_op
        fexp_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_op    (OP_TABLE[k]),
            .i_st    (w_st[k]),
            .o_st    (w_st[k+1])
        );
    end

    // scaling and output register
    fexp_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_st          (w_st[NUM_OPS]),
        .o_valid       (o_valid),
        .o_result_bits (o_result_bits)
    );

    // a stall towards the source only while a result is held
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    // an input transfer lands in the input register
    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s0.valid)
        else $error("accepted item missing from the input register");

    // reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

endmodule
